// File: hw/rtl/assert_macros.svh
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");

`endif

// File: hw/rtl/bad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bad_pkg;
  localparam int MaxWidth   = 4096;
  localparam int MaxBin     = 16;
  localparam int SampleBits = 24;
  localparam int ColBits    = 12;
  localparam int CntBits    = 9;
  localparam int SumBits    = 32;
  localparam int QBits      = 33;

  localparam logic [1:0] RegImageWidth  = 2'd0;
  localparam logic [1:0] RegImageHeight = 2'd1;
  localparam logic [1:0] RegBinWidth    = 2'd2;
  localparam logic [1:0] RegBinHeight   = 2'd3;

  // One finished box handed from the accumulator to the divider.
  typedef struct packed {
    logic signed [SumBits-1:0] sum;
    logic [CntBits-1:0]        count;
    logic [ColBits-1:0]        column;
    logic [ColBits-1:0]        line;
    logic                      last;
  } box_t;

  // Divider state machine states.
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;
endpackage
`default_nettype wire

// File: hw/rtl/bad_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle, with an output register.
module bad_divider import bad_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire box_t                         box,
  output logic                              busy,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [SampleBits-1:0]      average,
  output logic                              no_valid,
  output logic [ColBits-1:0]                out_column,
  output logic [ColBits-1:0]                out_line,
  output logic                              frame_end
);
  div_state_t state_r, state_nxt;
  logic [5:0]          step_r;
  logic [QBits-1:0]    quo_r;
  logic [CntBits:0]    rem_r;
  logic [CntBits-1:0]  den_r;
  logic                neg_r;
  box_t                box_r;
  logic [CntBits:0]    trial;
  logic [QBits-1:0]    qs;
  logic [CntBits:0]    rs;
  logic signed [QBits-1:0] res;
  logic                slot_free;
  logic                ov_r;
  logic signed [SampleBits-1:0] avg_r;
  logic                nv_r;
  logic [ColBits-1:0]  col_r;
  logic [ColBits-1:0]  line_r;
  logic                last_r;

  // Shift one dividend bit into the partial remainder.
  always_comb begin
    rs    = {rem_r[CntBits-1:0], quo_r[QBits-1]};
    qs    = {quo_r[QBits-2:0], 1'b0};
    trial = rs - {1'b0, den_r};
    res   = neg_r ? -$signed(quo_r) : $signed(quo_r);
  end

  // The output register can take a new result when empty or being drained.
  assign slot_free = !ov_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DIV_IDLE: if (start) state_nxt = DIV_RUN;
      DIV_RUN:  if (step_r == 6'(QBits - 1)) state_nxt = DIV_DONE;
      DIV_DONE: if (slot_free) state_nxt = DIV_IDLE;
      default:  state_nxt = DIV_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy       = (state_r != DIV_IDLE);
    out_valid  = ov_r;
    average    = avg_r;
    no_valid   = nv_r;
    out_column = col_r;
    out_line   = line_r;
    frame_end  = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == DIV_IDLE && start) begin
      box_r  <= box;
      neg_r  <= box.sum[SumBits-1];
      quo_r  <= box.sum[SumBits-1] ? -{{(QBits-SumBits){box.sum[SumBits-1]}}, box.sum}
                                   : {{(QBits-SumBits){1'b0}}, box.sum};
      rem_r  <= '0;
      den_r  <= box.count;
      step_r <= '0;
    end else if (state_r == DIV_RUN) begin
      step_r <= step_r + 6'd1;
      if (!trial[CntBits]) begin
        rem_r <= trial;
        quo_r <= qs | QBits'(1);
      end else begin
        rem_r <= rs;
        quo_r <= qs;
      end
    end
  end

  // Result register; a waiting result under output stall holds the divider in DIV_DONE.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (state_r == DIV_DONE && slot_free) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == DIV_DONE && slot_free) begin
      avg_r  <= (box_r.count == '0) ? '0 : res[SampleBits-1:0];
      nv_r   <= (box_r.count == '0);
      col_r  <= box_r.column;
      line_r <= box_r.line;
      last_r <= box_r.last;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_empty_zero, clk, rst_n, !out_valid || !no_valid || average == '0)
  `ASSERT_NEVER(a_start_busy, clk, rst_n, start && state_r != DIV_IDLE)
  `ASSERT_NEVER(a_step_range, clk, rst_n, state_r == DIV_RUN && step_r > 6'(QBits - 1))
endmodule
`default_nettype wire

// File: hw/rtl/box_average_downsample.sv
`timescale 1ns / 1ps
`default_nettype none
// Box-average downsampler. Pixels arrive in raster order; each transaction is
// read-modify-written into per-box-column sum and count memories (registered
// read, then write-back); the input is stalled for the write-back. A pixel
// that closes a box also starts a 33-step serial divider, and the input stays
// stalled until the quotient moves into the output register; a previous
// result still waiting under output stall delays that move. After reset and
// after each config write the number of whole boxes per row and per column is
// found by repeated subtraction, which stalls the input until both counts are
// found. Config writes restart the frame; memories need no clearing because
// each box reloads them.
module box_average_downsample import bad_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [SampleBits-1:0] in_sample,
  input  wire logic                     in_is_missing,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [SampleBits-1:0]  out_average,
  output logic                          out_no_valid,
  output logic [ColBits-1:0]            out_out_column,
  output logic [ColBits-1:0]            out_out_line,
  output logic                          out_frame_end,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [12:0]              cfg_data
);
  logic [12:0] iw_r, ih_r;
  logic [4:0]  bw_r, bh_r;
  logic [ColBits-1:0] px_r, py_r, bx_r, by_r;
  logic [12:0] nx_r, ny_r;
  logic [12:0] rw_r, rh_r;
  logic [3:0] ox_r, oy_r;
  logic [12:0] w, h;
  logic [4:0]  bw, bh;
  logic        busy_r;
  logic        pm_r, pact_r, pfirst_r, plast_r;
  logic signed [SampleBits-1:0] ps_r;
  logic [ColBits-1:0] pc_r, pl_r;
  logic        pend_r;
  logic        sizing;
  logic signed [SumBits-1:0] sum_mem [MaxWidth];
  logic [CntBits-1:0]        cnt_mem [MaxWidth];
  logic signed [SumBits-1:0] sum_rd;
  logic [CntBits-1:0]        cnt_rd;
  logic signed [SumBits-1:0] sum_new;
  logic [CntBits-1:0]        cnt_new;
  logic accept, active, first, lastp, div_busy, start;
  box_t box;

  // Effective sizes.
  always_comb begin
    w  = (iw_r == '0) ? 13'd1 : ((iw_r > 13'(MaxWidth)) ? 13'(MaxWidth) : iw_r);
    h  = (ih_r == '0) ? 13'd1 : ((ih_r > 13'(MaxWidth)) ? 13'(MaxWidth) : ih_r);
    bw = (bw_r == '0) ? 5'd1 : ((bw_r > 5'(MaxBin)) ? 5'(MaxBin) : bw_r);
    bh = (bh_r == '0) ? 5'd1 : ((bh_r > 5'(MaxBin)) ? 5'(MaxBin) : bh_r);
  end

  // Box counts are still being computed.
  assign sizing    = pend_r || (rw_r >= 13'(bw)) || (rh_r >= 13'(bh));
  assign in_stall  = busy_r || div_busy || sizing || cfg_valid;
  assign cfg_ready = !busy_r && !div_busy && !out_valid;
  assign accept    = in_valid && !in_stall;
  assign active    = (13'(bx_r) < nx_r) && (13'(by_r) < ny_r);
  assign first     = (ox_r == '0) && (oy_r == '0);
  assign lastp     = ({1'b0, ox_r} + 5'd1 >= bw) && ({1'b0, oy_r} + 5'd1 >= bh);

  // Config registers, and box counts by repeated subtraction after reset and after every config write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r <= 13'd3600; ih_r <= 13'd1440; bw_r <= 5'd5; bh_r <= 5'd4;
      pend_r <= 1'b1; nx_r <= '0; ny_r <= '0; rw_r <= '0; rh_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegImageWidth:  iw_r <= cfg_data;
        RegImageHeight: ih_r <= cfg_data;
        RegBinWidth:    bw_r <= cfg_data[4:0];
        RegBinHeight:   bh_r <= cfg_data[4:0];
        default: ;
      endcase
      pend_r <= 1'b1;
    end else if (pend_r) begin
      pend_r <= 1'b0; nx_r <= '0; ny_r <= '0; rw_r <= w; rh_r <= h;
    end else begin
      if (rw_r >= 13'(bw)) begin rw_r <= rw_r - 13'(bw); nx_r <= nx_r + 13'd1; end
      if (rh_r >= 13'(bh)) begin rh_r <= rh_r - 13'(bh); ny_r <= ny_r + 13'd1; end
    end
  end

  // Raster position.
  always_ff @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready)) begin
      px_r <= '0; py_r <= '0; ox_r <= '0; oy_r <= '0; bx_r <= '0; by_r <= '0;
    end else if (accept) begin
      if (13'(px_r) + 13'd1 >= w) begin
        px_r <= '0; ox_r <= '0; bx_r <= '0;
        if (13'(py_r) + 13'd1 >= h) begin
          py_r <= '0; oy_r <= '0; by_r <= '0;
        end else begin
          py_r <= py_r + 1'b1;
          if (5'(oy_r) + 5'd1 >= bh) begin oy_r <= '0; by_r <= by_r + 1'b1; end
          else oy_r <= oy_r + 1'b1;
        end
      end else begin
        px_r <= px_r + 1'b1;
        if (5'(ox_r) + 5'd1 >= bw) begin ox_r <= '0; bx_r <= bx_r + 1'b1; end
        else ox_r <= ox_r + 1'b1;
      end
    end
  end

  // Capture the transaction for the write-back cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= accept;
    if (accept) begin
      ps_r <= in_sample; pm_r <= in_is_missing; pact_r <= active;
      pfirst_r <= first; plast_r <= lastp; pc_r <= bx_r; pl_r <= by_r;
    end
  end

  // Memory read.
  always_ff @(posedge clk) begin
    sum_rd <= sum_mem[bx_r];
    cnt_rd <= cnt_mem[bx_r];
  end

  always_comb begin
    sum_new = (pfirst_r ? '0 : sum_rd) + (pm_r ? '0 : SumBits'(ps_r));
    cnt_new = (pfirst_r ? '0 : cnt_rd) + (pm_r ? '0 : CntBits'(1));
  end

  // Memory write-back.
  always_ff @(posedge clk) begin
    if (busy_r && pact_r) begin
      sum_mem[pc_r] <= sum_new;
      cnt_mem[pc_r] <= cnt_new;
    end
  end

  assign start      = busy_r && pact_r && plast_r;
  assign box.sum    = sum_new;
  assign box.count  = cnt_new;
  assign box.column = pc_r;
  assign box.line   = pl_r;
  assign box.last   = (13'(pc_r) + 13'd1 == nx_r) && (13'(pl_r) + 13'd1 == ny_r);

  bad_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(start), .box(box), .busy(div_busy),
    .out_valid(out_valid), .out_stall(out_stall), .average(out_average),
    .no_valid(out_no_valid), .out_column(out_out_column), .out_line(out_out_line),
    .frame_end(out_frame_end)
  );

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_no_accept_busy, clk, rst_n, accept && busy_r)
  `ASSERT_NEVER(a_cfg_while_busy, clk, rst_n, cfg_valid && cfg_ready && busy_r)
  `ASSERT_IMPL(a_start_idle, clk, rst_n, !start || busy_r)
endmodule
`default_nettype wire
